>>> rtl/ctg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the CTCSS tone generator.
package ctg_pkg;

  localparam int SineDepth    = 1024;
  localparam int SampleW      = 16;
  localparam int PhaseW       = 18;
  localparam int QuarterW     = 16;
  localparam int StepW        = 11;
  localparam int TenthsW      = 12;
  localparam int PeakW        = 15;
  localparam int SineW        = 15;
  localparam int CfgW         = 15;
  localparam int CfgIdxW      = 2;
  localparam int InDataW      = 8;
  localparam int AddrW        = $clog2(SineDepth + 1);
  localparam int ProdW        = PeakW + SineW;

  localparam longint unsigned PhaseMod     = 196608;
  localparam longint unsigned PhaseQuarter = 49152;
  localparam longint unsigned ReverseUnits = 130560;
  localparam longint unsigned HalfPiQ30    = 1686629713;
  localparam int              SineTerms    = 24;

  // step = floor(tenths * 256 / 625) as a reciprocal multiply
  localparam int              StepMulW  = 20;
  localparam longint unsigned StepMul   = 858994;
  localparam int              StepShift = 21;

  // table index = floor(r * SineDepth / PhaseQuarter) as a reciprocal multiply
  localparam int              IdxShift = 32;
  localparam longint unsigned IdxMul   =
    ((longint'(SineDepth) << IdxShift) + PhaseQuarter - 1) / PhaseQuarter;
  localparam int              IdxMulW  = $clog2(IdxMul + 1);

  localparam longint SampleMax = (longint'(1) << (SampleW - 1)) - 1;
  localparam longint SampleMin = -(longint'(1) << (SampleW - 1));

  typedef enum logic [CfgIdxW-1:0] {
    RegToneEnable = 2'd0,
    RegToneTenths = 2'd1,
    RegPeakLevel  = 2'd2
  } ctg_reg_e;

  typedef struct packed {
    logic             active;
    logic [StepW-1:0] step;
  } ctg_tone_t;

  typedef struct packed {
    logic vld;
    logic act;
    logic last;
  } ctg_ctl_t;

  typedef logic [SineDepth:0][SineW-1:0] sine_tab_t;

  // shift-subtract quotient, evaluated while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned part;
    quo  = 0;
    part = 0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[62:0], num[b]};
      if (part >= den) begin
        part   = part - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    logic            neg;
    for (int k = 0; k <= SineDepth; k++) begin
      x    = (HalfPiQ30 * longint'(k)) / SineDepth;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      n    = 1;
      neg  = 1'b1;
      for (int j = 0; j < SineTerms; j++) begin
        if (term != 0) begin
          term = (term * x2) >> 30;
          term = div_u64(term, (n + 1) * (n + 2));
          n    = n + 2;
          if (neg) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
          neg = ~neg;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = SineW'((longint'(32767) * sum + (longint'(1) << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

endpackage

>>> rtl/ctcss_tone_generator.sv
// Top level of the CTCSS tone generator: sample tick in, PCM tone sample out.
//
//   channel  direction  content
//   s_axis   in         tdata[0] reverse_burst, tlast block_end
//   m_axis   out        tdata[15:0] sample, tlast last_of_block
//   cfg      in         0 tone_enable, 1 tone_tenths_hz, 2 peak_level
//
// One tick accepted per cycle unless the pipeline is held; its sample is valid once it leaves the last stage.
// The four stages are phase update, table index, table read, amplitude multiply.
// The whole pipeline holds while a sample waits on m_axis_tready.
// Reset clears the phase, configuration and control registers to zero, not the data path; no start-up pass.
module ctcss_tone_generator import ctg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,   // [0] reverse_burst, [7:1] zero
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [SampleW-1:0] m_axis_tdata,   // [15:0] sample
  output logic               m_axis_tlast,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic              en;
  logic              accept;
  ctg_tone_t         tone;
  logic [PeakW-1:0]  peak;
  ctg_ctl_t          s1_ctl;
  logic [PhaseW-1:0] s1_phase;
  ctg_ctl_t          s3_ctl;
  logic [SineW-1:0]  s3_sin;
  logic              s3_neg;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  ctg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tone_o      (tone),
    .peak_o      (peak)
  );

  ctg_phase u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .accept_i   (accept),
    .burst_i    (s_axis_tdata[0]),
    .last_i     (s_axis_tlast),
    .tone_i     (tone),
    .s1_ctl_o   (s1_ctl),
    .s1_phase_o (s1_phase)
  );

  ctg_sine u_sine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .s1_ctl_i   (s1_ctl),
    .s1_phase_i (s1_phase),
    .s3_ctl_o   (s3_ctl),
    .s3_sin_o   (s3_sin),
    .s3_neg_o   (s3_neg)
  );

  ctg_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .s3_ctl_i     (s3_ctl),
    .s3_sin_i     (s3_sin),
    .s3_neg_i     (s3_neg),
    .peak_i       (peak),
    .out_vld_o    (m_axis_tvalid),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while the pipeline is held");
`endif

endmodule

>>> rtl/ctg_cfg.sv
// Configuration registers and the per-tick phase step of the CTCSS tone generator.
module ctg_cfg import ctg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output ctg_tone_t          tone_o,
  output logic [PeakW-1:0]   peak_o
);

  logic                          enable_q;
  logic                          tenths_nz_q;
  logic [StepW-1:0]              step_q;
  logic [PeakW-1:0]              peak_q;
  logic [TenthsW+StepMulW-1:0]   step_prod;
  logic [TenthsW-1:0]            wr_tenths;

  assign wr_tenths = cfg_wdata_i[TenthsW-1:0];
  assign step_prod = wr_tenths * StepMulW'(StepMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      tenths_nz_q <= 1'b0;
      step_q      <= '0;
      peak_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegToneEnable: enable_q <= cfg_wdata_i[0];
        RegToneTenths: begin
          tenths_nz_q <= |wr_tenths;
          step_q      <= StepW'(step_prod >> StepShift);
        end
        RegPeakLevel:  peak_q <= cfg_wdata_i[PeakW-1:0];
        default: ;
      endcase
    end
  end

  assign tone_o.active = enable_q & tenths_nz_q & (|peak_q);
  assign tone_o.step   = step_q;
  assign peak_o        = peak_q;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(1677))
    else $error("phase step out of range");
`endif

endmodule

>>> rtl/ctg_phase.sv
// Phase accumulator with reverse-burst jump and the first pipeline stage.
module ctg_phase import ctg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              accept_i,
  input  logic              burst_i,
  input  logic              last_i,
  input  ctg_tone_t         tone_i,
  output ctg_ctl_t          s1_ctl_o,
  output logic [PhaseW-1:0] s1_phase_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW:0]   burst_sum;
  logic [PhaseW-1:0] burst_phase;
  logic [PhaseW-1:0] tick_phase;
  logic [PhaseW:0]   step_sum;
  ctg_ctl_t          s1_ctl_q, s1_ctl_d;
  logic [PhaseW-1:0] s1_phase_q;

  always_comb begin
    burst_sum   = {1'b0, phase_q} + (PhaseW + 1)'(ReverseUnits);
    burst_phase = (burst_sum >= (PhaseW + 1)'(PhaseMod)) ?
                  PhaseW'(burst_sum - (PhaseW + 1)'(PhaseMod)) : PhaseW'(burst_sum);
    tick_phase  = burst_i ? burst_phase : phase_q;
    step_sum    = {1'b0, tick_phase} + (PhaseW + 1)'(tone_i.step);
    phase_d     = phase_q;
    if (accept_i && tone_i.active) begin
      phase_d = (step_sum >= (PhaseW + 1)'(PhaseMod)) ?
                PhaseW'(step_sum - (PhaseW + 1)'(PhaseMod)) : PhaseW'(step_sum);
    end
    s1_ctl_d.vld  = accept_i;
    s1_ctl_d.act  = tone_i.active;
    s1_ctl_d.last = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      s1_ctl_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (en_i) begin
        s1_ctl_q <= s1_ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_phase_q <= tick_phase;
    end
  end

  assign s1_ctl_o   = s1_ctl_q;
  assign s1_phase_o = s1_phase_q;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PhaseW'(PhaseMod))
    else $error("phase accumulator beyond one cycle");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept_i && tone_i.active) |=> $stable(phase_q))
    else $error("phase moved without an active request");
`endif

endmodule

>>> rtl/ctg_sine.sv
// Quadrant fold, table index and registered quarter-wave sine lookup.
module ctg_sine import ctg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ctg_ctl_t          s1_ctl_i,
  input  logic [PhaseW-1:0] s1_phase_i,
  output ctg_ctl_t          s3_ctl_o,
  output logic [SineW-1:0]  s3_sin_o,
  output logic              s3_neg_o
);

  logic [1:0]                  quad;
  logic [QuarterW-1:0]         rem;
  logic [QuarterW+IdxMulW-1:0] idx_prod;
  logic [AddrW-1:0]            idx;
  logic [AddrW-1:0]            s2_addr_q, s2_addr_d;
  logic                        s2_neg_q;
  ctg_ctl_t                    s2_ctl_q;
  logic [SineW-1:0]            s3_sin_q;
  logic                        s3_neg_q;
  ctg_ctl_t                    s3_ctl_q;

  always_comb begin
    if (s1_phase_i >= PhaseW'(3 * PhaseQuarter)) begin
      quad = 2'd3;
      rem  = QuarterW'(s1_phase_i - PhaseW'(3 * PhaseQuarter));
    end else if (s1_phase_i >= PhaseW'(2 * PhaseQuarter)) begin
      quad = 2'd2;
      rem  = QuarterW'(s1_phase_i - PhaseW'(2 * PhaseQuarter));
    end else if (s1_phase_i >= PhaseW'(PhaseQuarter)) begin
      quad = 2'd1;
      rem  = QuarterW'(s1_phase_i - PhaseW'(PhaseQuarter));
    end else begin
      quad = 2'd0;
      rem  = QuarterW'(s1_phase_i);
    end
    idx_prod  = rem * IdxMulW'(IdxMul);
    idx       = AddrW'(idx_prod >> IdxShift);
    s2_addr_d = quad[0] ? AddrW'(SineDepth) - idx : idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (en_i) begin
      s2_ctl_q <= s1_ctl_i;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_addr_q <= s2_addr_d;
      s2_neg_q  <= quad[1];
      s3_sin_q  <= SineTab[s2_addr_q];
      s3_neg_q  <= s2_neg_q;
    end
  end

  assign s3_ctl_o = s3_ctl_q;
  assign s3_sin_o = s3_sin_q;
  assign s3_neg_o = s3_neg_q;

`ifndef SYNTHESIS
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_ctl_q.vld |-> s2_addr_q <= AddrW'(SineDepth))
    else $error("sine table address beyond the quarter wave");
`endif

endmodule

>>> rtl/ctg_scale.sv
// Amplitude scaling, floor rounding and the output register.
module ctg_scale import ctg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ctg_ctl_t           s3_ctl_i,
  input  logic [SineW-1:0]   s3_sin_i,
  input  logic               s3_neg_i,
  input  logic [PeakW-1:0]   peak_i,
  output logic               out_vld_o,
  output logic [SampleW-1:0] out_sample_o,
  output logic               out_last_o
);

  logic [ProdW-1:0]        prod;
  logic [ProdW:0]          neg_sum;
  logic signed [ProdW:0]   scaled;
  logic [SampleW-1:0]      sample_d;
  logic                    out_vld_q;
  logic [SampleW-1:0]      out_sample_q;
  logic                    out_last_q;

  always_comb begin
    prod    = peak_i * s3_sin_i;
    neg_sum = {1'b0, prod} + (ProdW + 1)'(32767);
    if (s3_neg_i) begin
      scaled = -$signed((ProdW + 1)'(neg_sum >> 15));
    end else begin
      scaled = $signed((ProdW + 1)'(prod >> 15));
    end
    if (!s3_ctl_i.act) begin
      sample_d = '0;
    end else if (scaled > (ProdW + 1)'(SampleMax)) begin
      sample_d = SampleW'(SampleMax);
    end else if (scaled < $signed((ProdW + 1)'(SampleMin))) begin
      sample_d = SampleW'(SampleMin);
    end else begin
      sample_d = SampleW'(scaled);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= s3_ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_sample_q <= sample_d;
      out_last_q   <= s3_ctl_i.last;
    end
  end

  assign out_vld_o    = out_vld_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && s3_ctl_i.vld && !s3_ctl_i.act) |=> (out_vld_q && out_sample_q == '0))
    else $error("silent tick produced a nonzero sample");
`endif

endmodule
